FILE: rtl/kdpt_pkg.sv
// Package for the kinship divergence pair test: genotype codes, widths,
// the reset cutoff and the lane result types. No dependencies.
`default_nettype none

package kdpt_pkg;

	localparam int GENO_W    = 8;
	localparam int LANES     = 4;
	localparam int PAIR_W    = 21;
	localparam int HETSUM_W  = 22;
	localparam int BELOW_W   = 17;
	localparam int CUTOFF_W  = 18;
	localparam int LCNT_W    = 3;

	// 2-bit genotype codes
	localparam logic [1:0] GENO_HOM_REF = 2'd0;
	localparam logic [1:0] GENO_MISSING = 2'd1;
	localparam logic [1:0] GENO_HET     = 2'd2;
	localparam logic [1:0] GENO_HOM_ALT = 2'd3;

	// -0.025 in Q16
	localparam logic signed [CUTOFF_W-1:0] CUTOFF_RESET = -18'sd1638;

	typedef struct packed {
		logic hethet;
		logic homopp;
	} lane_res_t;

	typedef struct packed {
		logic [LCNT_W-1:0] hethet;
		logic [LCNT_W-1:0] homopp;
	} byte_cnt_t;

endpackage

`default_nettype wire

FILE: rtl/kdpt_if.sv
// Handshake channel interfaces for the kinship divergence pair test.
// Depends on kdpt_pkg for field widths.
`default_nettype none

interface kdpt_in_if;
	logic                              valid;
	logic                              ready;
	logic [kdpt_pkg::GENO_W-1:0]       geno_a;
	logic [kdpt_pkg::GENO_W-1:0]       geno_b;
	logic                              last_byte;
	logic [kdpt_pkg::HETSUM_W-1:0]     het_sum;
	logic                              new_reference;

	modport source (output valid, geno_a, geno_b, last_byte, het_sum, new_reference,
		input ready);
	modport sink (input valid, geno_a, geno_b, last_byte, het_sum, new_reference,
		output ready);
endinterface

interface kdpt_out_if;
	logic                              valid;
	logic                              ready;
	logic [kdpt_pkg::PAIR_W-1:0]       hethet_count;
	logic [kdpt_pkg::PAIR_W-1:0]       homopp_count;
	logic                              below_cutoff;
	logic [kdpt_pkg::BELOW_W-1:0]      below_total;

	modport source (output valid, hethet_count, homopp_count, below_cutoff, below_total,
		input ready);
	modport sink (input valid, hethet_count, homopp_count, below_cutoff, below_total,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/kdpt_lane.sv
// One genotype lane: classifies a pair of 2-bit codes as het-het or
// opposite homozygous. Depends on kdpt_pkg.
`default_nettype none

module kdpt_lane (
	input  wire logic [1:0]          ga,
	input  wire logic [1:0]          gb,
	output kdpt_pkg::lane_res_t      res
);

	always_comb begin
		res.hethet = (ga == kdpt_pkg::GENO_HET) && (gb == kdpt_pkg::GENO_HET);
		res.homopp = ((ga == kdpt_pkg::GENO_HOM_ALT) && (gb == kdpt_pkg::GENO_HOM_REF)) ||
			((ga == kdpt_pkg::GENO_HOM_REF) && (gb == kdpt_pkg::GENO_HOM_ALT));
	end

endmodule

`default_nettype wire

FILE: rtl/kdpt_merge.sv
// Merge stage: adds the lane flags of one byte into per-byte counts.
// Depends on kdpt_pkg.
`default_nettype none

module kdpt_merge (
	input  wire kdpt_pkg::lane_res_t [kdpt_pkg::LANES-1:0] lanes,
	output kdpt_pkg::byte_cnt_t                            cnt
);

	always_comb begin
		cnt = '0;
		for (int i = 0; i < kdpt_pkg::LANES; i++) begin
			cnt.hethet = cnt.hethet + kdpt_pkg::LCNT_W'(lanes[i].hethet);
			cnt.homopp = cnt.homopp + kdpt_pkg::LCNT_W'(lanes[i].homopp);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kinship_divergence_pair_test.sv
// Top level of the kinship divergence pair test: four genotype lanes, merge,
// pair accumulators, cutoff test and running below count.
// Depends on kdpt_pkg, kdpt_if, kdpt_lane and kdpt_merge.
//
//  channel | direction | item                                        | handshake
//  --------+-----------+---------------------------------------------+-----------
//  geno    | in        | geno_a, geno_b, last_byte, het_sum, new_ref | valid/ready
//  result  | out       | hethet_count, homopp_count, below_cutoff,   | valid/ready
//          |           | below_total (one per last byte)             |
//  cfg     | in        | cutoff_q16, 18-bit signed Q16               | cfg_wr_en
//
// One item per cycle sustained while the result side does not stall. An item is
// counted by the lanes and added to the pair accumulators at its accept edge,
// where stage 1 registers it; a last byte's result is loaded into the output
// register when stage 1 advances, which can wait on a stalled result. The 18x23
// cutoff multiply is registered in stage 1 ahead of the compare. Reset clears the
// accumulators, running count, stage valids and loads the cutoff with -0.025 in
// Q16. A stalled result holds stage 1; bytes that are not last never wait on the output side.
`default_nettype none

module kinship_divergence_pair_test (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [kdpt_pkg::CUTOFF_W-1:0]     cfg_wr_data,
	kdpt_in_if.sink                                geno,
	kdpt_out_if.source                             result
);

	localparam int PW = kdpt_pkg::PAIR_W;
	localparam int BW = kdpt_pkg::BELOW_W;
	localparam int NUM_W  = PW + 2;                       // hethet - 2*homopp
	localparam int PROD_W = kdpt_pkg::CUTOFF_W + kdpt_pkg::HETSUM_W + 1;

	// Saturating add of a byte count to a pair accumulator.
	function automatic logic [PW-1:0] sat_pair(input logic [PW-1:0] acc,
		input logic [kdpt_pkg::LCNT_W-1:0] inc);
		logic [PW:0] s;
		s = {1'b0, acc} + (PW+1)'(inc);
		return s[PW] ? {PW{1'b1}} : s[PW-1:0];
	endfunction

	// Register
	logic signed [kdpt_pkg::CUTOFF_W-1:0] cutoff_q;

	// Lanes and merge
	kdpt_pkg::lane_res_t [kdpt_pkg::LANES-1:0] lane_res;
	kdpt_pkg::byte_cnt_t                       byte_cnt;

	for (genvar g = 0; g < kdpt_pkg::LANES; g++) begin : g_lane
		kdpt_lane u_lane (
			.ga  (geno.geno_a[2*g +: 2]),
			.gb  (geno.geno_b[2*g +: 2]),
			.res (lane_res[g])
		);
	end

	kdpt_merge u_merge (
		.lanes (lane_res),
		.cnt   (byte_cnt)
	);

	// Pair accumulators
	logic [PW-1:0] hethet_acc_q, homopp_acc_q;
	logic [PW-1:0] hethet_sum, homopp_sum;

	assign hethet_sum = sat_pair(hethet_acc_q, byte_cnt.hethet);
	assign homopp_sum = sat_pair(homopp_acc_q, byte_cnt.homopp);

	// Stage 1
	logic                      valid_s1, last_s1, new_ref_s1;
	logic [PW-1:0]             hethet_s1, homopp_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  prod;

	assign prod = PROD_W'(cutoff_q) * PROD_W'($signed({1'b0, geno.het_sum}));

	// Running count and output register
	logic [BW-1:0] below_q;
	logic          out_valid_q;

	logic in_fire, out_free, adv_s1, load_out;
	assign in_fire  = geno.valid && geno.ready;
	assign out_free = !out_valid_q || result.ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign load_out = adv_s1 && last_s1;
	assign geno.ready = !valid_s1 || adv_s1;

	// Cutoff test: num * 2^16 < cutoff * het_sum
	logic signed [NUM_W-1:0]  num;
	logic signed [PROD_W-1:0] lhs;
	logic                     below;
	logic [BW-1:0]            below_base, below_nxt;

	always_comb begin
		num = $signed({2'b00, hethet_s1}) - $signed({1'b0, homopp_s1, 1'b0});
		lhs = PROD_W'($signed({num, 16'b0}));
		below = lhs < prod_s1;
		below_base = new_ref_s1 ? '0 : below_q;
		below_nxt  = below_base;
		if (last_s1 && below && below_base != {BW{1'b1}}) begin
			below_nxt = below_base + BW'(1);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q     <= kdpt_pkg::CUTOFF_RESET;
			hethet_acc_q <= '0;
			homopp_acc_q <= '0;
			valid_s1     <= 1'b0;
			below_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cutoff_q <= $signed(cfg_wr_data);
			end
			// Clear the pair counters after a last byte, otherwise accumulate
			if (in_fire) begin
				hethet_acc_q <= geno.last_byte ? '0 : hethet_sum;
				homopp_acc_q <= geno.last_byte ? '0 : homopp_sum;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				below_q <= below_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_s1    <= geno.last_byte;
			new_ref_s1 <= geno.new_reference;
			hethet_s1  <= hethet_sum;
			homopp_s1  <= homopp_sum;
			prod_s1    <= prod;
		end
		if (load_out) begin
			result.hethet_count <= hethet_s1;
			result.homopp_count <= homopp_s1;
			result.below_cutoff <= below;
			result.below_total  <= below_nxt;
		end
	end

	assign result.valid = out_valid_q;

	// Pair counters restart after every accepted last byte
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && geno.last_byte) |=> (hethet_acc_q == '0 && homopp_acc_q == '0))
		else $error("pair accumulators not cleared after last byte");

	// A result appears only from a last byte in stage 1
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a last byte");

	// Running count never drops without a new reference
	a_below_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !new_ref_s1) |=> (below_q >= $past(below_q)))
		else $error("running below count decreased");

endmodule

`default_nettype wire

FILE: dv/kinship_divergence_pair_test_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for kinship_divergence_pair_test: streams genotype byte pairs,
// predicts every pair result in step with the accepted items and checks each one.
// Depends on kdpt_pkg, kdpt_in_if / kdpt_out_if and the block's RTL.

module kinship_divergence_pair_test_tb;

	localparam int GENO_W   = kdpt_pkg::GENO_W;
	localparam int LANES    = kdpt_pkg::LANES;
	localparam int PAIR_W   = kdpt_pkg::PAIR_W;
	localparam int HETSUM_W = kdpt_pkg::HETSUM_W;
	localparam int BELOW_W  = kdpt_pkg::BELOW_W;
	localparam int CUTOFF_W = kdpt_pkg::CUTOFF_W;

	localparam logic [1:0] GENO_HOM_REF = kdpt_pkg::GENO_HOM_REF;
	localparam logic [1:0] GENO_HET     = kdpt_pkg::GENO_HET;
	localparam logic [1:0] GENO_HOM_ALT = kdpt_pkg::GENO_HOM_ALT;
	localparam logic signed [CUTOFF_W-1:0] CUTOFF_RESET = kdpt_pkg::CUTOFF_RESET;

	localparam int unsigned PAIR_MAX        = (1 << PAIR_W) - 1;
	localparam int unsigned BELOW_MAX       = (1 << BELOW_W) - 1;
	localparam longint      Q16_ONE         = 65536;
	// Longest stretch with no handshake at all; longer than the long hold-off.
	localparam int          STALL_LIMIT     = 4000;
	// Margin for the pipeline to drain after the last result.
	localparam int          DRAIN_CYCLES    = 8;
	localparam int          SETTLE_CYCLES   = 4;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          RANDOM_ITEMS    = 170;

	localparam logic [GENO_W-1:0] ALL_HET  = 8'hAA;
	localparam logic [GENO_W-1:0] ALL_ALT  = 8'hFF;
	localparam logic [GENO_W-1:0] ALL_REF  = 8'h00;
	localparam logic [GENO_W-1:0] ALL_MISS = 8'h55;

	typedef struct packed {
		logic [PAIR_W-1:0]  hethet;
		logic [PAIR_W-1:0]  homopp;
		logic               below;
		logic [BELOW_W-1:0] total;
	} pair_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CUTOFF_W-1:0] cfg_wr_data;

	kdpt_in_if  geno_ch();
	kdpt_out_if res_ch();

	kinship_divergence_pair_test u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.geno        (geno_ch),
		.result      (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the block: cutoff register, pair counters and running below count.
	logic signed [CUTOFF_W-1:0] cutoff_shadow;
	int unsigned                hethet_tally;
	int unsigned                homopp_tally;
	int unsigned                below_tally;
	pair_result_t               expected_pairs[$];

	int mismatches    = 0;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int hold_cycles   = 0;

	function automatic int unsigned sat_add(input int unsigned acc, input int unsigned inc,
			input int unsigned lim);
		int unsigned s;
		s = acc + inc;
		return (s > lim) ? lim : s;
	endfunction

	// Advance the shadow by one accepted byte; queue the pair result on a last byte.
	task automatic tally_geno_byte(input logic [GENO_W-1:0] a, input logic [GENO_W-1:0] b,
			input logic last, input logic [HETSUM_W-1:0] hs, input logic nr);
		int unsigned n_hh;
		int unsigned n_ho;
		logic [1:0]  ga;
		logic [1:0]  gb;
		longint      margin;
		longint      lhs;
		longint      rhs;
		logic        is_below;
		n_hh = 0;
		n_ho = 0;
		// A new reference clears the running count before this byte counts.
		if (nr)
			below_tally = 0;
		for (int lane = 0; lane < LANES; lane++) begin
			ga = a[2*lane +: 2];
			gb = b[2*lane +: 2];
			if (ga == GENO_HET && gb == GENO_HET)
				n_hh++;
			else if ((ga == GENO_HOM_ALT && gb == GENO_HOM_REF) ||
					(ga == GENO_HOM_REF && gb == GENO_HOM_ALT))
				n_ho++;
		end
		hethet_tally = sat_add(hethet_tally, n_hh, PAIR_MAX);
		homopp_tally = sat_add(homopp_tally, n_ho, PAIR_MAX);
		if (last) begin
			// Cross-multiplied divergence test; a zero het_sum leaves only the sign.
			margin   = longint'(hethet_tally) - 2 * longint'(homopp_tally);
			lhs      = margin * Q16_ONE;
			rhs      = longint'(cutoff_shadow) * longint'(hs);
			is_below = (lhs < rhs);
			if (is_below)
				below_tally = sat_add(below_tally, 1, BELOW_MAX);
			expected_pairs.push_back('{hethet: PAIR_W'(hethet_tally),
				homopp: PAIR_W'(homopp_tally), below: is_below,
				total: BELOW_W'(below_tally)});
			hethet_tally = 0;
			homopp_tally = 0;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endtask

	// Offer one item, idling first at the sender's rate; hold valid high between
	// back-to-back items so it is never dropped and raised in the same step.
	task automatic send_byte(input logic [GENO_W-1:0] a, input logic [GENO_W-1:0] b,
			input logic last, input logic [HETSUM_W-1:0] hs, input logic nr);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			geno_ch.valid <= 1'b0;
			@(posedge clk);
		end
		geno_ch.valid         <= 1'b1;
		geno_ch.geno_a        <= a;
		geno_ch.geno_b        <= b;
		geno_ch.last_byte     <= last;
		geno_ch.het_sum       <= hs;
		geno_ch.new_reference <= nr;
		// Ready is sampled as it stood at the edge, before the edge updates it.
		@(posedge clk iff geno_ch.ready);
		tally_geno_byte(a, b, last, hs, nr);
	endtask

	// Write the cutoff only with the block idle: drain results, then let trailing
	// bytes that produce no result clear the pipeline.
	task automatic set_cutoff(input logic [CUTOFF_W-1:0] value);
		geno_ch.valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		cutoff_shadow = value;
	endtask

	function automatic logic [HETSUM_W-1:0] pick_het_sum();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return HETSUM_W'($urandom_range(1, 63));
			2:       return HETSUM_W'($urandom_range(0, 4095));
			3:       return HETSUM_W'($urandom_range(0, 262143));
			default: return HETSUM_W'($urandom);
		endcase
	endfunction

	// Partner byte that shares, flips or rerolls lanes so het-het and opposite
	// homozygous lanes turn up often.
	function automatic logic [GENO_W-1:0] partner_byte(input logic [GENO_W-1:0] a);
		logic [GENO_W-1:0] b;
		b = a;
		for (int lane = 0; lane < LANES; lane++) begin
			case ($urandom_range(0, 3))
				0:       b[2*lane +: 2] = ~a[2*lane +: 2];
				1:       b[2*lane +: 2] = 2'($urandom_range(0, 3));
				default: ;
			endcase
		end
		return b;
	endfunction

	// Result checker: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_pairs.size() == 0) begin
				flag_mismatch("result with nothing expected", 0,
					longint'(res_ch.hethet_count));
			end else begin
				want = expected_pairs.pop_front();
				if (res_ch.hethet_count !== want.hethet)
					flag_mismatch("hethet_count", longint'(want.hethet),
						longint'(res_ch.hethet_count));
				if (res_ch.homopp_count !== want.homopp)
					flag_mismatch("homopp_count", longint'(want.homopp),
						longint'(res_ch.homopp_count));
				if (res_ch.below_cutoff !== want.below)
					flag_mismatch("below_cutoff", longint'(want.below),
						longint'(res_ch.below_cutoff));
				if (res_ch.below_total !== want.total)
					flag_mismatch("below_total", longint'(want.total),
						longint'(res_ch.below_total));
			end
		end
	end

	// Receiver: stall at the sink's rate, or hold ready low through a hold-off.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves an item.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (geno_ch.valid && geno_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Extreme bytes, zero and full het_sum, new reference on a last byte and
	// mid-pair, and the exact boundary of the cutoff test.
	task automatic test_directed();
		send_byte(ALL_REF, ALL_REF, 1'b1, '0, 1'b1);
		send_byte(ALL_ALT, ALL_ALT, 1'b1, '1, 1'b0);
		send_byte(ALL_HET, ALL_HET, 1'b1, '0, 1'b0);
		send_byte(ALL_ALT, ALL_REF, 1'b1, '0, 1'b0);
		send_byte(ALL_REF, ALL_ALT, 1'b1, '1, 1'b0);
		send_byte(ALL_MISS, ALL_MISS, 1'b1, 22'd1, 1'b0);
		// two-byte pair: four het-het lanes, then four opposite lanes
		send_byte(ALL_HET, ALL_HET, 1'b0, '0, 1'b0);
		send_byte(8'h0F, 8'hF0, 1'b1, 22'd100, 1'b0);
		send_byte(ALL_ALT, ALL_REF, 1'b1, '0, 1'b1);
		// three-byte pair with a new reference on its first and second byte
		send_byte(8'hE4, 8'h1B, 1'b0, '1, 1'b1);
		send_byte(8'h1B, 8'hE4, 1'b0, '0, 1'b1);
		send_byte(ALL_HET, 8'hAE, 1'b1, 22'd7, 1'b0);
		// cutoff -1.0 and margin -4: het_sum 4 sits on the boundary, not below
		set_cutoff(-18'sd65536);
		send_byte(8'h0F, ALL_REF, 1'b1, 22'd4, 1'b0);
		send_byte(8'h0F, ALL_REF, 1'b1, 22'd3, 1'b0);
		send_byte(8'h0F, ALL_REF, 1'b1, 22'd5, 1'b0);
	endtask

	// Both ends of the full register range, the stated range, zero and reset.
	task automatic test_cutoff_extremes();
		int                cutoffs[6];
		logic [GENO_W-1:0] a;
		cutoffs = '{-131072, 131071, -65536, 65536, 0, int'(CUTOFF_RESET)};
		foreach (cutoffs[i]) begin
			set_cutoff(CUTOFF_W'(cutoffs[i]));
			a = GENO_W'($urandom_range(0, 255));
			send_byte(a, partner_byte(a), 1'b1, '1, 1'b0);
			a = GENO_W'($urandom_range(0, 255));
			send_byte(a, partner_byte(a), 1'b1, pick_het_sum(), 1'b0);
		end
	endtask

	// Mostly well-formed pairs of random length and content, with runs per
	// reference; one in ten pairs is broken with random last and reference marks.
	task automatic test_random_pairs(input int n_items);
		int                sent;
		int                len;
		bit                broken;
		bit                fresh_ref;
		logic [GENO_W-1:0] a;
		logic [GENO_W-1:0] b;
		logic              last;
		logic              nr;
		sent = 0;
		while (sent < n_items) begin
			len       = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
			broken    = ($urandom_range(0, 9) == 0);
			fresh_ref = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++) begin
				a    = GENO_W'($urandom_range(0, 255));
				b    = ($urandom_range(0, 1) != 0) ? partner_byte(a) : GENO_W'($urandom);
				last = (i == len - 1);
				nr   = fresh_ref && (i == 0);
				if (broken) begin
					last = 1'($urandom_range(0, 1));
					nr   = ($urandom_range(0, 3) == 0);
				end
				send_byte(a, b, last, pick_het_sum(), nr);
				sent++;
			end
		end
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering,
	// so results back up and the block stalls its input.
	task automatic test_backpressure();
		int                saved_idle;
		logic [GENO_W-1:0] a;
		saved_idle   = src_idle_pct;
		src_idle_pct = 0;
		hold_cycles  = HOLD_OFF_CYCLES;
		repeat (60) begin
			a = GENO_W'($urandom_range(0, 255));
			send_byte(a, partner_byte(a), ($urandom_range(0, 3) != 0), pick_het_sum(), 1'b0);
		end
		src_idle_pct = saved_idle;
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		geno_ch.valid         = 1'b0;
		geno_ch.geno_a        = '0;
		geno_ch.geno_b        = '0;
		geno_ch.last_byte     = 1'b0;
		geno_ch.het_sum       = '0;
		geno_ch.new_reference = 1'b0;
		cutoff_shadow         = CUTOFF_RESET;
		hethet_tally          = 0;
		homopp_tally          = 0;
		below_tally           = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalled.
		src_idle_pct  = 23;
		sink_idle_pct = 76;
		test_directed();
		test_cutoff_extremes();
		test_random_pairs(RANDOM_ITEMS);

		// Sender mostly idle, receiver mostly ready.
		set_cutoff(CUTOFF_W'($urandom_range(0, 131072) - 65536));
		src_idle_pct  = 76;
		sink_idle_pct = 23;
		test_random_pairs(RANDOM_ITEMS);
		test_backpressure();

		// Full rate on both sides.
		set_cutoff(CUTOFF_W'($urandom_range(0, 131072) - 65536));
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_pairs(RANDOM_ITEMS);

		// Drain: wait for every expected result, then the pipeline latency.
		geno_ch.valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/kdpt_pkg.sv
rtl/kdpt_if.sv
rtl/kdpt_lane.sv
rtl/kdpt_merge.sv
rtl/kinship_divergence_pair_test.sv
dv/kinship_divergence_pair_test_tb.sv
